### hdl/pdmcic_pkg.sv
// Shared types and constants for the third-order CIC PDM decimator.
// Used by the lane, merge, filter and statistics modules and by the top level.
// No dependencies.
package pdmcic_pkg;

    localparam int LANES  = 16;
    localparam int LANE_W = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 3'd3;

    localparam logic [15:0]        GAIN_RESET = 16'd256;
    localparam logic signed [15:0] PCM_MAX    = 16'sh7FFF;
    localparam logic signed [15:0] PCM_MIN    = 16'sh8000;
    localparam logic [23:0]        COUNT_MAX  = 24'hFFFFFF;

    // Control that travels with every item through the pipeline.
    typedef struct packed {
        logic valid;
        logic restart;
        logic sample;
    } tok_t;

    // Weighted contributions of one bit to the three integrators.
    typedef struct packed {
        logic signed [LANE_W-1:0] s1;
        logic signed [LANE_W-1:0] s2;
        logic signed [LANE_W-1:0] s3;
    } lane_t;

endpackage

### hdl/pdmcic_lane.sv
// One bit lane: picks its PDM bit, applies inversion and maps it to +1/-1
// weighted by its position in the word. Depends on pdmcic_pkg.
module pdmcic_lane #(
    parameter int LANE = 0
) (
    input  logic [pdmcic_pkg::LANES-1:0] pdm_word,
    input  logic                         invert_bits,
    input  logic                         msb_first,
    output pdmcic_pkg::lane_t            contrib
);
    import pdmcic_pkg::*;

    // A bit that is k-th in time reaches the second integrator (16 - k) times
    // and the third integrator (16 - k)(17 - k)/2 times within the word.
    localparam int W2 = LANES - LANE;
    localparam int W3 = (LANES - LANE) * (LANES + 1 - LANE) / 2;
    localparam logic signed [LANE_W-1:0] P1 = LANE_W'(1);
    localparam logic signed [LANE_W-1:0] P2 = LANE_W'(W2);
    localparam logic signed [LANE_W-1:0] P3 = LANE_W'(W3);

    logic bit_val;

    always_comb
    begin
        bit_val = (msb_first ? pdm_word[LANES-1-LANE] : pdm_word[LANE]) ^ invert_bits;
        contrib.s1 = bit_val ? P1 : -P1;
        contrib.s2 = bit_val ? P2 : -P2;
        contrib.s3 = bit_val ? P3 : -P3;
    end

endmodule

### hdl/pdmcic_merge.sv
// Merging stage: adds the sixteen lane contributions into the per-word
// integrator increments and registers them with the item's control.
// Depends on pdmcic_pkg.
module pdmcic_merge (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      adv,
    input  logic                                      in_valid,
    input  logic                                      restart,
    input  pdmcic_pkg::lane_t [pdmcic_pkg::LANES-1:0] contribs,
    output pdmcic_pkg::tok_t                          tok_a,
    output pdmcic_pkg::lane_t                         sums_a
);
    import pdmcic_pkg::*;

    localparam int GRP  = 4;
    localparam int NGRP = LANES / GRP;

    logic signed [LANE_W-1:0] grp1 [NGRP];
    logic signed [LANE_W-1:0] grp2 [NGRP];
    logic signed [LANE_W-1:0] grp3 [NGRP];
    lane_t sums_next;
    tok_t  tok_a_reg;
    lane_t sums_reg;

    // Partial sums never exceed the total of the weights, so LANE_W holds them.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp1[g] = '0;
            grp2[g] = '0;
            grp3[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                grp1[g] = grp1[g] + contribs[g*GRP+k].s1;
                grp2[g] = grp2[g] + contribs[g*GRP+k].s2;
                grp3[g] = grp3[g] + contribs[g*GRP+k].s3;
            end
        end
        sums_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            sums_next.s1 = sums_next.s1 + grp1[g];
            sums_next.s2 = sums_next.s2 + grp2[g];
            sums_next.s3 = sums_next.s3 + grp3[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
        end
        else if (adv)
        begin
            tok_a_reg.valid   <= in_valid;
            tok_a_reg.restart <= restart;
            tok_a_reg.sample  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sums_reg <= sums_next;
        end
    end

    assign tok_a  = tok_a_reg;
    assign sums_a = sums_reg;

endmodule

### hdl/pdmcic_filter.sv
// Integrators, combs and gain scaling of the CIC decimator, as a pipeline
// that takes one word per cycle while adv is high. Depends on pdmcic_pkg.
module pdmcic_filter #(
    parameter int DECIMATION = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  pdmcic_pkg::tok_t         tok_a,
    input  pdmcic_pkg::lane_t        sums_a,
    input  logic [15:0]              gain_q8,
    output pdmcic_pkg::tok_t         tok_g,
    output logic signed [15:0]       pcm_g,
    output logic [31:0]              square_g
);
    import pdmcic_pkg::*;

    localparam int LOG_D    = $clog2(DECIMATION);
    localparam int CW       = 3 * LOG_D + 2;
    localparam int MAG_W    = CW - 1;
    localparam int PROD_W   = MAG_W + 16;
    localparam int FULL_W   = PROD_W + 15;
    localparam int SCALE_SH = 3 * $clog2(LANES) + 8;
    localparam int WORDS    = DECIMATION / LANES;
    localparam int PH_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int DIV_D    = WORDS * WORDS * WORDS;
    localparam int DIV_LOG  = $clog2(DIV_D);
    localparam int Q_IN_W   = $clog2(32769 * DIV_D);
    localparam int NX_W     = (FULL_W - SCALE_SH > Q_IN_W) ? FULL_W - SCALE_SH : Q_IN_W;
    localparam int RSH      = Q_IN_W + DIV_LOG;
    localparam int R_W      = Q_IN_W + 2;
    localparam int QP_W     = Q_IN_W + R_W;
    localparam longint unsigned RECIP = ((64'd1 << RSH) + DIV_D - 1) / DIV_D;

    localparam logic [PH_W-1:0]       LAST_PHASE = PH_W'(WORDS - 1);
    localparam logic [CW-1:0]         LANES_C    = CW'(LANES);
    localparam logic [CW-1:0]         TRI_C      = CW'(LANES * (LANES + 1) / 2);
    localparam logic [R_W-1:0]        RECIP_C    = R_W'(RECIP);
    localparam logic [NX_W-1:0]       LIM_POS    = NX_W'(32768 * DIV_D);
    localparam logic [NX_W-1:0]       LIM_NEG    = NX_W'(32769 * DIV_D);
    localparam logic signed [CW-1:0]  COMB_PEAK  = CW'(DECIMATION * DECIMATION * DECIMATION);

    // Integrator stage.
    logic [PH_W-1:0] phase_reg, phase_next, cur_phase;
    logic            is_sample;
    logic [CW-1:0]   i1_reg, i2_reg, i3_reg;
    logic [CW-1:0]   i1_base, i2_base, i3_base;
    logic [CW-1:0]   i1_next, i2_next, i3_next;
    logic [CW-1:0]   s1x, s2x, s3x;
    tok_t            tok_b_reg;

    // Comb stage.
    logic [CW-1:0]         d1_reg, d2_reg, d3_reg;
    logic [CW-1:0]         d1_base, d2_base, d3_base;
    logic [CW-1:0]         c1, c2, c3;
    logic signed [CW-1:0]  c3_reg;
    tok_t                  tok_c_reg;

    // Scaling stages.
    logic               neg_c;
    logic [MAG_W-1:0]   mag_c;
    logic [PROD_W-1:0]  prod_d_reg;
    logic               neg_d_reg;
    tok_t               tok_d_reg;

    logic [FULL_W-1:0]  full_d;
    logic [NX_W-1:0]    nx_d;
    logic               sat_d;
    logic [Q_IN_W-1:0]  nlo_e_reg;
    logic               neg_e_reg, sat_e_reg;
    tok_t               tok_e_reg;

    logic [QP_W-1:0]    qprod_e;
    logic [15:0]        q_f_reg;
    logic               neg_f_reg, sat_f_reg;
    tok_t               tok_f_reg;

    logic signed [15:0] pcm_f;
    logic signed [31:0] square_f;
    logic signed [15:0] pcm_g_reg;
    logic [31:0]        square_g_reg;
    tok_t               tok_g_reg;

    // A word advances each integrator by sixteen steps at once: the closed
    // form needs the earlier integrator values times 16 and times 136.
    always_comb
    begin
        cur_phase  = tok_a.restart ? '0 : phase_reg;
        is_sample  = (cur_phase == LAST_PHASE);
        phase_next = is_sample ? '0 : cur_phase + 1'b1;
        i1_base    = tok_a.restart ? '0 : i1_reg;
        i2_base    = tok_a.restart ? '0 : i2_reg;
        i3_base    = tok_a.restart ? '0 : i3_reg;
        s1x        = CW'(sums_a.s1);
        s2x        = CW'(sums_a.s2);
        s3x        = CW'(sums_a.s3);
        i1_next    = i1_base + s1x;
        i2_next    = i2_base + i1_base * LANES_C + s2x;
        i3_next    = i3_base + i2_base * LANES_C + i1_base * TRI_C + s3x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            i1_reg    <= '0;
            i2_reg    <= '0;
            i3_reg    <= '0;
            tok_b_reg <= '0;
        end
        else if (adv)
        begin
            tok_b_reg.valid   <= tok_a.valid;
            tok_b_reg.restart <= tok_a.restart;
            tok_b_reg.sample  <= tok_a.valid & is_sample;
            if (tok_a.valid)
            begin
                phase_reg <= phase_next;
                i1_reg    <= i1_next;
                i2_reg    <= i2_next;
                i3_reg    <= i3_next;
            end
        end
    end

    // Combs run only on the word that completes a decimation period.
    always_comb
    begin
        d1_base = tok_b_reg.restart ? '0 : d1_reg;
        d2_base = tok_b_reg.restart ? '0 : d2_reg;
        d3_base = tok_b_reg.restart ? '0 : d3_reg;
        c1      = i3_reg - d1_base;
        c2      = c1 - d2_base;
        c3      = c2 - d3_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg    <= '0;
            d2_reg    <= '0;
            d3_reg    <= '0;
            tok_c_reg <= '0;
        end
        else if (adv)
        begin
            tok_c_reg <= tok_b_reg;
            if (tok_b_reg.valid)
            begin
                d1_reg <= tok_b_reg.sample ? i3_reg : d1_base;
                d2_reg <= tok_b_reg.sample ? c1 : d2_base;
                d3_reg <= tok_b_reg.sample ? c2 : d3_base;
            end
        end
    end

    // The divisor DECIMATION^3 * 256 splits into a right shift by 20 bits and a
    // division by (DECIMATION/16)^3, done as a multiply by its reciprocal.
    // Values beyond the int16 range saturate before that multiply.
    always_comb
    begin
        neg_c   = c3_reg[CW-1];
        mag_c   = MAG_W'(neg_c ? -c3_reg : c3_reg);
        full_d  = {prod_d_reg, 15'b0} - FULL_W'(prod_d_reg);
        nx_d    = NX_W'(full_d >> SCALE_SH);
        sat_d   = neg_d_reg ? (nx_d >= LIM_NEG) : (nx_d >= LIM_POS);
        qprod_e = QP_W'(nlo_e_reg) * QP_W'(RECIP_C);
        if (sat_f_reg)
        begin
            pcm_f = neg_f_reg ? PCM_MIN : PCM_MAX;
        end
        else
        begin
            pcm_f = neg_f_reg ? -$signed(q_f_reg) : $signed(q_f_reg);
        end
        square_f = 32'(pcm_f) * 32'(pcm_f);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_d_reg <= '0;
            tok_e_reg <= '0;
            tok_f_reg <= '0;
            tok_g_reg <= '0;
        end
        else if (adv)
        begin
            tok_d_reg <= tok_c_reg;
            tok_e_reg <= tok_d_reg;
            tok_f_reg <= tok_e_reg;
            tok_g_reg <= tok_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c3_reg       <= c3;
            prod_d_reg   <= PROD_W'(mag_c) * PROD_W'(gain_q8);
            neg_d_reg    <= neg_c;
            nlo_e_reg    <= nx_d[Q_IN_W-1:0];
            neg_e_reg    <= neg_d_reg;
            sat_e_reg    <= sat_d;
            q_f_reg      <= qprod_e[RSH +: 16];
            neg_f_reg    <= neg_e_reg;
            sat_f_reg    <= sat_e_reg;
            pcm_g_reg    <= pcm_f;
            square_g_reg <= square_f;
        end
    end

    assign tok_g    = tok_g_reg;
    assign pcm_g    = pcm_g_reg;
    assign square_g = square_g_reg;

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= LAST_PHASE)
        else $error("decimation phase beyond its period");

    a_comb_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_c_reg.valid && tok_c_reg.sample) |->
            (c3_reg <= COMB_PEAK && c3_reg >= -COMB_PEAK))
        else $error("comb output outside full scale");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_f_reg.valid && tok_f_reg.sample && !sat_f_reg) |->
            (q_f_reg <= 16'd32768))
        else $error("scaled quotient exceeds int16 magnitude");

endmodule

### hdl/pdmcic_stats.sv
// Warmup discard, running statistics and the output register.
// Depends on pdmcic_pkg.
module pdmcic_stats (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  pdmcic_pkg::tok_t         tok_g,
    input  logic signed [15:0]       pcm_g,
    input  logic [31:0]              square_g,
    input  logic [15:0]              warmup_frames,
    output logic                     out_valid,
    output logic signed [15:0]       pcm_sample,
    output logic signed [15:0]       min_sample,
    output logic signed [15:0]       max_sample,
    output logic [23:0]              sample_count,
    output logic signed [39:0]       sample_sum,
    output logic [54:0]              sample_square_sum
);
    import pdmcic_pkg::*;

    logic [15:0]        warm_reg, warm_next;
    logic signed [39:0] sum_reg, sum_next;
    logic [54:0]        sq_reg, sq_next;
    logic signed [15:0] min_reg, min_next;
    logic signed [15:0] max_reg, max_next;
    logic [23:0]        cnt_reg, cnt_next;
    logic               emit;

    logic               out_valid_reg;
    logic signed [15:0] pcm_out_reg, min_out_reg, max_out_reg;
    logic [23:0]        cnt_out_reg;
    logic signed [39:0] sum_out_reg;
    logic [54:0]        sq_out_reg;

    // A restart clears the statistics before the item's own sample is counted.
    always_comb
    begin
        warm_next = tok_g.restart ? warmup_frames : warm_reg;
        sum_next  = tok_g.restart ? '0 : sum_reg;
        sq_next   = tok_g.restart ? '0 : sq_reg;
        min_next  = tok_g.restart ? PCM_MAX : min_reg;
        max_next  = tok_g.restart ? PCM_MIN : max_reg;
        cnt_next  = tok_g.restart ? '0 : cnt_reg;
        emit      = 1'b0;
        if (tok_g.sample)
        begin
            if (warm_next != '0)
            begin
                warm_next = warm_next - 1'b1;
            end
            else
            begin
                emit = 1'b1;
                if (cnt_next != COUNT_MAX)
                begin
                    sum_next = sum_next + 40'(pcm_g);
                    sq_next  = sq_next + 55'(square_g);
                    if (pcm_g < min_next)
                    begin
                        min_next = pcm_g;
                    end
                    if (pcm_g > max_next)
                    begin
                        max_next = pcm_g;
                    end
                    cnt_next = cnt_next + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            min_reg       <= PCM_MAX;
            max_reg       <= PCM_MIN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tok_g.valid & emit;
            if (tok_g.valid)
            begin
                warm_reg <= warm_next;
                sum_reg  <= sum_next;
                sq_reg   <= sq_next;
                min_reg  <= min_next;
                max_reg  <= max_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tok_g.valid && emit)
        begin
            pcm_out_reg <= pcm_g;
            min_out_reg <= min_next;
            max_out_reg <= max_next;
            cnt_out_reg <= cnt_next;
            sum_out_reg <= sum_next;
            sq_out_reg  <= sq_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pcm_sample        = pcm_out_reg;
    assign min_sample        = min_out_reg;
    assign max_sample        = max_out_reg;
    assign sample_count      = cnt_out_reg;
    assign sample_sum        = sum_out_reg;
    assign sample_square_sum = sq_out_reg;

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above running maximum");

    a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (min_reg == PCM_MAX && max_reg == PCM_MIN && sum_reg == '0))
        else $error("statistics not at their cleared values with no samples");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(cnt_reg) && $stable(sum_reg) && $stable(warm_reg)))
        else $error("statistics changed while the pipeline was held");

endmodule

### hdl/pdm_cic3_decimator_with_stats.sv
// Third-order CIC decimator for packed PDM with running sample statistics.
// Top level: configuration registers, sixteen bit lanes, merge, filter and
// statistics. Depends on pdmcic_pkg and all pdmcic_* modules.
//
// Usage:
//   Input items carry a 16-bit PDM word and a restart flag on in_valid /
//   in_stall; a word is taken at a rising edge with in_valid high and in_stall
//   low. A restart clears the filter and the statistics and reloads the warmup
//   count before its own word. Every DECIMATION/16 words complete one decimated
//   sample; after warmup_frames dropped samples each sample is offered on
//   out_valid / out_stall together with min, max, count, sum and sum of
//   squares that include it until the count saturates.
//   Throughput is one word per cycle while the pipeline is not held. A word's
//   result passes through one merge stage, integrators, combs, three scaling
//   stages (gain multiply, saturation, reciprocal multiply), sample forming and
//   the output register before it shows on the output.
//   While out_valid is high and out_stall is held, the whole pipeline holds
//   and in_stall is raised; otherwise words keep flowing.
//   Reset empties the pipeline, clears filter and statistics and sets gain to
//   unity, no inversion, LSB-first bit order and no warmup. Configuration
//   writes take effect at once and are meant for an idle block.
module pdm_cic3_decimator_with_stats #(
    parameter int DECIMATION = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [pdmcic_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pdmcic_pkg::LANES-1:0]         pdm_word,
    input  logic                                 restart,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [15:0]                   pcm_sample,
    output logic signed [15:0]                   min_sample,
    output logic signed [15:0]                   max_sample,
    output logic [23:0]                          sample_count,
    output logic signed [39:0]                   sample_sum,
    output logic [54:0]                          sample_square_sum
);
    import pdmcic_pkg::*;

    logic [15:0] gain_reg;
    logic        invert_reg;
    logic        msb_first_reg;
    logic [15:0] warmup_reg;

    logic                   adv;
    lane_t [LANES-1:0]      contribs;
    tok_t                   tok_a, tok_g;
    lane_t                  sums_a;
    logic signed [15:0]     pcm_g;
    logic [31:0]            square_g;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            invert_reg    <= 1'b0;
            msb_first_reg <= 1'b0;
            warmup_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GAIN:      gain_reg      <= cfg_data;
                CFG_INVERT:    invert_reg    <= cfg_data[0];
                CFG_MSB_FIRST: msb_first_reg <= cfg_data[0];
                CFG_WARMUP:    warmup_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The pipeline moves only when the output register can take a result.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        pdmcic_lane #(
            .LANE (k)
        ) u_lane (
            .pdm_word    (pdm_word),
            .invert_bits (invert_reg),
            .msb_first   (msb_first_reg),
            .contrib     (contribs[k])
        );
    end

    pdmcic_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .restart  (restart),
        .contribs (contribs),
        .tok_a    (tok_a),
        .sums_a   (sums_a)
    );

    pdmcic_filter #(
        .DECIMATION (DECIMATION)
    ) u_filter (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .tok_a    (tok_a),
        .sums_a   (sums_a),
        .gain_q8  (gain_reg),
        .tok_g    (tok_g),
        .pcm_g    (pcm_g),
        .square_g (square_g)
    );

    pdmcic_stats u_stats (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .tok_g             (tok_g),
        .pcm_g             (pcm_g),
        .square_g          (square_g),
        .warmup_frames     (warmup_reg),
        .out_valid         (out_valid),
        .pcm_sample        (pcm_sample),
        .min_sample        (min_sample),
        .max_sample        (max_sample),
        .sample_count      (sample_count),
        .sample_sum        (sample_sum),
        .sample_square_sum (sample_square_sum)
    );

endmodule
